// ===== rtl/core/tpsd_pkg.sv =====
// Shared types and constants for the TGA pixel stream decoder.
package tpsd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DimW   = 16;
  localparam int unsigned IdxW   = 32;
  localparam int unsigned CfgIdW = 3;

  // Pixel format codes as written to the format register.
  localparam logic [2:0] FMT_RAW16 = 3'd0;
  localparam logic [2:0] FMT_RAW24 = 3'd1;
  localparam logic [2:0] FMT_RAW32 = 3'd2;
  localparam logic [2:0] FMT_RLE24 = 3'd3;
  localparam logic [2:0] FMT_RLE32 = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdW-1:0] REG_PIXEL_FORMAT = 3'd0;
  localparam logic [CfgIdW-1:0] REG_FLIP_ROWS    = 3'd1;
  localparam logic [CfgIdW-1:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CfgIdW-1:0] REG_IMAGE_HEIGHT = 3'd3;

  // RLE packet header: values at or above this start a repeat packet.
  localparam logic [ByteW-1:0] RLE_REPEAT_MIN = 8'd128;
  localparam logic [ByteW-1:0] RLE_REPEAT_OFS = 8'd127;

  typedef struct packed {
    logic [2:0]      fmt;
    logic            flip;
    logic [DimW-1:0] width;       // zero already replaced by one
    logic [IdxW-1:0] total;       // width * height
    logic [IdxW-1:0] top_base;    // (height - 1) * width
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0]  pixel_index;
    logic [ByteW-1:0] run_length;
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] alpha;
    logic             last;
  } pix_t;

endpackage

// ===== rtl/core/tpsd_cfg.sv =====
// Configuration registers and the registered image size products.
module tpsd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tpsd_pkg::CfgIdW-1:0] cfg_index_i,
  input  logic [tpsd_pkg::DimW-1:0]   cfg_wdata_i,
  output tpsd_pkg::cfg_t              cfg_o,
  output logic                        restart_o
);
  import tpsd_pkg::*;

  logic [2:0]      fmt_q;
  logic            flip_q;
  logic [DimW-1:0] width_q;
  logic [DimW-1:0] height_q;
  logic [IdxW-1:0] total_q;
  logic [IdxW-1:0] top_base_q;
  logic [DimW-1:0] w_eff;
  logic [DimW-1:0] h_eff;
  logic [DimW-1:0] h_less;

  assign w_eff  = (width_q == '0) ? DimW'(1) : width_q;
  assign h_eff  = (height_q == '0) ? DimW'(1) : height_q;
  assign h_less = h_eff - DimW'(1);

  assign restart_o = cfg_we_i && (cfg_index_i <= REG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q      <= FMT_RAW24;
      flip_q     <= 1'b1;
      width_q    <= DimW'(1);
      height_q   <= DimW'(1);
      total_q    <= IdxW'(1);
      top_base_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PIXEL_FORMAT: fmt_q    <= cfg_wdata_i[2:0];
          REG_FLIP_ROWS:    flip_q   <= cfg_wdata_i[0];
          REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
          REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      // Products follow the size registers in the next cycle.
      total_q    <= IdxW'(w_eff) * IdxW'(h_eff);
      top_base_q <= IdxW'(h_less) * IdxW'(w_eff);
    end
  end

  assign cfg_o.fmt      = fmt_q;
  assign cfg_o.flip     = flip_q;
  assign cfg_o.width    = w_eff;
  assign cfg_o.total    = total_q;
  assign cfg_o.top_base = top_base_q;

endmodule

// ===== rtl/core/tpsd_decode.sv =====
// Decoder state and the combinational byte decode that forms one pixel run.
module tpsd_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tpsd_pkg::cfg_t             cfg_i,
  input  logic                       restart_i,
  input  logic                       take_i,
  input  logic [tpsd_pkg::ByteW-1:0] byte_i,
  output logic                       res_valid_o,
  output tpsd_pkg::pix_t             res_o
);
  import tpsd_pkg::*;

  logic             exp_hdr_q, exp_hdr_d;
  logic             rep_q, rep_d;
  logic [ByteW-1:0] left_q, left_d;
  logic [1:0]       bip_q, bip_d;
  logic [ByteW-1:0] cb_q [4];
  logic [IdxW-1:0]  done_q, done_d;
  logic [DimW-1:0]  col_q, col_d;
  logic [IdxW-1:0]  base_q, base_d;
  logic             base_ok_q, base_ok_d;

  logic             known, rle, rgb_raw, four, hdr;
  logic [2:0]       need;
  logic [1:0]       bip_inc;
  logic             px_done, emit;
  logic [ByteW-1:0] cb [4];
  logic [15:0]      word;
  logic [ByteW-1:0] run_raw;
  logic [IdxW-1:0]  rem;
  logic             last;
  logic [ByteW-1:0] run;
  logic [IdxW-1:0]  base_cur;
  logic [DimW:0]    col_p1;
  logic             wrap;

  assign known   = cfg_i.fmt <= FMT_RLE32;
  assign rle     = (cfg_i.fmt == FMT_RLE24) || (cfg_i.fmt == FMT_RLE32);
  assign rgb_raw = (cfg_i.fmt == FMT_RAW24) || (cfg_i.fmt == FMT_RAW32);
  assign four    = (cfg_i.fmt == FMT_RAW32) || (cfg_i.fmt == FMT_RLE32);
  assign need    = (cfg_i.fmt == FMT_RAW16) ? 3'd2 : (four ? 3'd4 : 3'd3);
  assign hdr     = rle && exp_hdr_q;
  assign bip_inc = bip_q + 2'd1;
  assign px_done = (bip_inc == 2'd0) || ({1'b0, bip_inc} >= need);
  assign emit    = take_i && known && !hdr && px_done;

  // The byte completing the pixel is merged in before it is stored.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cb[k] = (bip_q == 2'(k)) ? byte_i : cb_q[k];
    end
  end

  assign word = {cb[1], cb[0]};

  always_comb begin
    left_d = left_q;
    rep_d  = rep_q;
    run_raw = 8'd1;
    if (rle) begin
      if (rep_q) begin
        run_raw = (left_q != '0) ? left_q : 8'd1;
        left_d  = '0;
      end else if (left_q != '0) begin
        left_d = left_q - 8'd1;
      end
    end
  end

  // Clip at the image end; the clipped run ends the image exactly.
  assign rem  = cfg_i.total - done_q;
  assign last = rem <= {24'd0, run_raw};
  assign run  = last ? rem[ByteW-1:0] : run_raw;

  assign base_cur = base_ok_q ? base_q : cfg_i.top_base;
  assign col_p1   = {1'b0, col_q} + 17'd1;
  assign wrap     = col_p1 >= {1'b0, cfg_i.width};

  always_comb begin
    exp_hdr_d = exp_hdr_q;
    bip_d     = bip_q;
    done_d    = done_q;
    col_d     = col_q;
    base_d    = base_q;
    base_ok_d = base_ok_q;
    if (take_i && known) begin
      if (hdr) begin
        exp_hdr_d = 1'b0;
        bip_d     = '0;
      end else if (!px_done) begin
        bip_d = bip_inc;
      end else begin
        bip_d  = '0;
        done_d = done_q + {24'd0, run};
        if (rle && left_d == '0) begin
          exp_hdr_d = 1'b1;
        end
        if (rgb_raw) begin
          base_ok_d = 1'b1;
          if (wrap) begin
            col_d  = '0;
            base_d = base_cur - {16'd0, cfg_i.width};
          end else begin
            col_d  = col_p1[DimW-1:0];
            base_d = base_cur;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_hdr_q <= 1'b1;
      rep_q     <= 1'b0;
      left_q    <= '0;
      bip_q     <= '0;
      done_q    <= '0;
      col_q     <= '0;
      base_q    <= '0;
      base_ok_q <= 1'b0;
    end else if (restart_i || (emit && last)) begin
      exp_hdr_q <= 1'b1;
      rep_q     <= 1'b0;
      left_q    <= '0;
      bip_q     <= '0;
      done_q    <= '0;
      col_q     <= '0;
      base_ok_q <= 1'b0;
    end else if (take_i && known) begin
      if (hdr) begin
        rep_q  <= byte_i >= RLE_REPEAT_MIN;
        left_q <= (byte_i >= RLE_REPEAT_MIN) ? byte_i - RLE_REPEAT_OFS : byte_i + 8'd1;
      end else if (px_done) begin
        rep_q  <= rep_d;
        left_q <= left_d;
      end
      exp_hdr_q <= exp_hdr_d;
      bip_q     <= bip_d;
      done_q    <= done_d;
      col_q     <= col_d;
      base_q    <= base_d;
      base_ok_q <= base_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && known && !hdr) begin
      cb_q[bip_q] <= byte_i;
    end
  end

  always_comb begin
    res_o.run_length = run;
    res_o.last       = last;
    res_o.pixel_index = (rgb_raw && cfg_i.flip) ? base_cur + {16'd0, col_q} : done_q;
    if (cfg_i.fmt == FMT_RAW16) begin
      res_o.blue  = {word[4:0], 3'b000};
      res_o.green = {word[9:5], 3'b000};
      res_o.red   = {word[14:10], 3'b000};
      res_o.alpha = '0;
    end else begin
      res_o.red   = cb[2];
      res_o.green = cb[1];
      res_o.blue  = cb[0];
      res_o.alpha = four ? cb[3] : '0;
    end
  end

  assign res_valid_o = emit;

endmodule

// ===== rtl/core/tga_pixel_stream_decoder_core.sv =====
// Top level of the TGA pixel stream decoder: input register, decode and result register.
//
// The block takes the pixel-data section of a TGA image one byte per word on the
// input channel (in_valid_i / in_stall_o) and gives decoded pixel runs on the
// output channel (out_valid_o / out_stall_i): start index, run length, RGBA and
// an end-of-image flag. A word moves when valid is high and stall is low.
// Formats are raw 16-bit 5:5:5, raw 24/32-bit BGR(A) with optional bottom-up
// rows, and RLE 24/32-bit packets; a repeat packet comes out as one run.
// An accepted byte waits in the input register, then is decoded into the result
// register, where its run appears on the output.
// One byte is taken every cycle; the only limit is the result register, so the
// input stalls only while a run sits unaccepted and a byte waits behind it in
// the input register.
// Bytes that complete no pixel (headers, partial pixels) give no word out.
// Configuration is a plain write port; any write to a known register restarts
// decoding of the image. Width times height is registered from the size registers,
// so it trails a write; bytes taken meanwhile see the old product. Reset restores
// 24-bit raw, flipped rows and a one by one image, and empties both registers.
module tga_pixel_stream_decoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tpsd_pkg::CfgIdW-1:0] cfg_index_i,
  input  logic [tpsd_pkg::DimW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tpsd_pkg::ByteW-1:0]  data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tpsd_pkg::IdxW-1:0]   pixel_index_o,
  output logic [tpsd_pkg::ByteW-1:0]  run_length_o,
  output logic [tpsd_pkg::ByteW-1:0]  red_o,
  output logic [tpsd_pkg::ByteW-1:0]  green_o,
  output logic [tpsd_pkg::ByteW-1:0]  blue_o,
  output logic [tpsd_pkg::ByteW-1:0]  alpha_o,
  output logic                        last_of_image_o
);
  import tpsd_pkg::*;

  cfg_t             cfg;
  logic             restart;
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_free;
  logic             take;
  logic             res_valid;
  pix_t             res;
  logic             out_vld_q;
  pix_t             out_q;

  tpsd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .restart_o   (restart)
  );

  // The result register can load when it is empty or being emptied now.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign take       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= data_byte_i;
    end
  end

  tpsd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .restart_i   (restart),
    .take_i      (take),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= take && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && take && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign pixel_index_o   = out_q.pixel_index;
  assign run_length_o    = out_q.run_length;
  assign red_o           = out_q.red;
  assign green_o         = out_q.green;
  assign blue_o          = out_q.blue;
  assign alpha_o         = out_q.alpha;
  assign last_of_image_o = out_q.last;

  // The input side only backs up behind a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // Every run covers at least one pixel and at most one full packet.
  a_run_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((run_length_o != 8'd0) && (run_length_o <= 8'd128)))
    else $error("run length out of range");

  // A run only appears after a byte was decoded in the previous cycle.
  a_run_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(take && res_valid))
    else $error("result appeared without a decoded byte");

endmodule
